@@ src/urfw_pkg.sv @@
// Shared constants and types of the receive ring, transmit tracker and link watchdog.
`default_nettype none

package urfw_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [2:0] CMD_RX_BYTE   = 3'd0;
    localparam logic [2:0] CMD_READ      = 3'd1;
    localparam logic [2:0] CMD_TX_START  = 3'd2;
    localparam logic [2:0] CMD_TX_READY  = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;
    localparam logic [2:0] CMD_CLR_DEAD  = 3'd5;
    localparam logic [2:0] CMD_CLR_START = 3'd6;
    localparam logic [2:0] CMD_CLR_STOP  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BUSY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIME   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TIME = 1'd1;

    localparam logic [CFG_W-1:0] GAP_TIME_RST   = 16'd10;
    localparam logic [CFG_W-1:0] RESET_TIME_RST = 16'd1000;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] data;
    } ring_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count_next;
        logic             empty;
        logic             full;
        logic [7:0]       head;
    } ring_stat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       read_byte;
        logic             send_next;
        logic [CNT_W-1:0] queue_count;
        logic             tx_busy;
        logic             link_dead;
        logic             frame_start;
        logic             frame_stop;
        logic             soft_reset;
    } result_t;

endpackage

`default_nettype wire

@@ src/urfw_ring.sv @@
// Receive byte ring: storage, read and write indexes, fill count and head byte.
`default_nettype none

module urfw_ring (
    input  logic                   clk,
    input  logic                   rst_n,
    input  urfw_pkg::ring_cmd_t    ring_cmd,
    output urfw_pkg::ring_stat_t   ring_stat
);
    import urfw_pkg::*;

    logic [QIDX_W-1:0] wr_idx_reg;
    logic [QIDX_W-1:0] wr_idx_next;
    logic [QIDX_W-1:0] rd_idx_reg;
    logic [QIDX_W-1:0] rd_idx_next;
    logic [QIDX_W-1:0] wr_addr;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              wr_en;
    logic              full;
    logic              empty;
    logic [7:0]        rx_store_reg [QUEUE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [7:0]        byp_data_reg;
    logic              byp_reg;

    function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] i);
        if (i == QIDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        wr_addr     = wr_idx_reg;
        wr_en       = 1'b0;
        if (ring_cmd.clear) begin
            wr_idx_next = '0;
            rd_idx_next = '0;
            count_next  = '0;
        end
        else begin
            if (ring_cmd.push) begin
                wr_en = 1'b1;
                if (full) begin
                    // The newest slot is overwritten when the ring is full.
                    wr_addr = (wr_idx_reg == '0) ? QIDX_W'(QUEUE_DEPTH - 1)
                                                 : wr_idx_reg - 1'b1;
                end
                else begin
                    wr_idx_next = idx_inc(wr_idx_reg);
                    count_next  = count_reg + 1'b1;
                end
            end
            if (ring_cmd.pop && !empty) begin
                rd_idx_next = idx_inc(rd_idx_reg);
                count_next  = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            rx_store_reg[wr_addr] <= ring_cmd.data;
        end
        rd_data_reg  <= rx_store_reg[rd_idx_next];
        byp_data_reg <= ring_cmd.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            byp_reg    <= 1'b0;
        end
        else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
            // A write to the slot that becomes the head is forwarded past the memory.
            byp_reg    <= wr_en && (wr_addr == rd_idx_next);
        end
    end

    assign ring_stat.count_next = count_next;
    assign ring_stat.empty      = empty;
    assign ring_stat.full       = full;
    assign ring_stat.head       = byp_reg ? byp_data_reg : rd_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ring fill count exceeds depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ring_cmd.clear |=> (count_reg == '0 && wr_idx_reg == '0 && rd_idx_reg == '0))
        else $error("ring not empty after clear");

    a_index_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != CNT_W'(QUEUE_DEPTH)) |-> wr_idx_reg != rd_idx_reg)
        else $error("ring indexes disagree with fill count");

endmodule

`default_nettype wire

@@ src/urfw_core.sv @@
// Command decode, transmit length tracker, frame gap detector and idle watchdog.
`default_nettype none

module urfw_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [2:0]                        cmd,
    input  logic [7:0]                        data,
    input  logic [15:0]                       tx_length,
    input  logic                              rx_error,
    input  logic [urfw_pkg::CFG_W-1:0]        gap_time,
    input  logic [urfw_pkg::CFG_W-1:0]        reset_time,
    input  urfw_pkg::ring_stat_t              ring_stat,
    output urfw_pkg::ring_cmd_t               ring_cmd,
    output urfw_pkg::result_t                 result
);
    import urfw_pkg::*;

    logic [15:0] tx_rem_reg,  tx_rem_next;
    logic        tx_active_reg, tx_active_next;
    logic        rx_ok_reg,   rx_ok_next;
    logic        tx_ok_reg,   tx_ok_next;
    logic [15:0] gap_cnt_reg, gap_cnt_next;
    logic [15:0] rx_idle_reg, rx_idle_next;
    logic [15:0] tx_idle_reg, tx_idle_next;
    logic        dead_reg,    dead_next;
    logic        start_reg,   start_next;
    logic        stop_reg,    stop_next;
    logic [15:0] gap_tmp;
    logic [15:0] rx_tmp;
    logic [15:0] tx_tmp;
    logic        expired;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    always_comb
    begin
        tx_rem_next    = tx_rem_reg;
        tx_active_next = tx_active_reg;
        rx_ok_next     = rx_ok_reg;
        tx_ok_next     = tx_ok_reg;
        gap_cnt_next   = gap_cnt_reg;
        rx_idle_next   = rx_idle_reg;
        tx_idle_next   = tx_idle_reg;
        dead_next      = dead_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        gap_tmp        = gap_cnt_reg;
        rx_tmp         = rx_idle_reg;
        tx_tmp         = tx_idle_reg;
        expired        = 1'b0;
        ring_cmd       = '0;
        ring_cmd.data  = data;
        result         = '0;

        case (cmd)
            CMD_RX_BYTE: begin
                ring_cmd.push = en;
                if (ring_stat.full) begin
                    result.status = ST_FULL;
                end
            end
            CMD_READ: begin
                if (ring_stat.empty) begin
                    result.status = ST_EMPTY;
                end
                else begin
                    ring_cmd.pop     = en;
                    result.read_byte = ring_stat.head;
                    rx_ok_next       = 1'b1;
                end
            end
            CMD_TX_START: begin
                if (tx_active_reg) begin
                    result.status = ST_BUSY;
                end
                else begin
                    tx_active_next = 1'b1;
                    tx_ok_next     = 1'b1;
                    if (tx_length != 16'd0) begin
                        result.send_next = 1'b1;
                        tx_rem_next      = tx_length - 16'd1;
                    end
                    else begin
                        tx_rem_next = 16'd0;
                    end
                end
            end
            CMD_TX_READY: begin
                if (tx_active_reg) begin
                    if (tx_rem_reg == 16'd0) begin
                        tx_active_next = 1'b0;
                    end
                    else begin
                        result.send_next = 1'b1;
                        tx_rem_next      = tx_rem_reg - 16'd1;
                    end
                end
            end
            CMD_TICK: begin
                gap_tmp = bump(gap_cnt_reg);
                if (rx_ok_reg) begin
                    gap_tmp    = 16'd0;
                    start_next = 1'b0;
                end
                if (gap_tmp >= gap_time) begin
                    gap_tmp = 16'd0;
                    if (!start_next) begin
                        start_next = 1'b1;
                        stop_next  = 1'b1;
                    end
                end
                rx_tmp     = bump(rx_idle_reg);
                tx_tmp     = bump(tx_idle_reg);
                rx_ok_next = 1'b0;
                if (rx_ok_reg) begin
                    rx_tmp = 16'd0;
                end
                if (tx_ok_reg) begin
                    tx_ok_next = 1'b0;
                    dead_next  = 1'b0;
                    tx_tmp     = 16'd0;
                end
                if (rx_tmp >= reset_time) begin
                    rx_tmp = reset_time;
                end
                if (tx_tmp >= reset_time) begin
                    tx_tmp = reset_time;
                end
                expired      = (rx_tmp >= reset_time) || (tx_tmp >= reset_time);
                gap_cnt_next = gap_tmp;
                rx_idle_next = rx_tmp;
                tx_idle_next = tx_tmp;
                if (expired || rx_error) begin
                    if (expired) begin
                        rx_idle_next = 16'd0;
                        tx_idle_next = 16'd0;
                        dead_next    = 1'b1;
                    end
                    tx_rem_next       = 16'd0;
                    tx_active_next    = 1'b0;
                    rx_ok_next        = 1'b0;
                    tx_ok_next        = 1'b0;
                    gap_cnt_next      = 16'd0;
                    start_next        = 1'b0;
                    stop_next         = 1'b0;
                    ring_cmd.clear    = en;
                    result.soft_reset = 1'b1;
                end
            end
            CMD_CLR_DEAD: begin
                dead_next = 1'b0;
            end
            CMD_CLR_START: begin
                start_next = 1'b0;
            end
            CMD_CLR_STOP: begin
                stop_next = 1'b0;
            end
            default: begin
            end
        endcase

        result.queue_count = ring_stat.count_next;
        result.tx_busy     = tx_active_next;
        result.link_dead   = dead_next;
        result.frame_start = start_next;
        result.frame_stop  = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tx_rem_reg    <= '0;
            tx_active_reg <= 1'b0;
            rx_ok_reg     <= 1'b0;
            tx_ok_reg     <= 1'b0;
            gap_cnt_reg   <= '0;
            rx_idle_reg   <= '0;
            tx_idle_reg   <= '0;
            dead_reg      <= 1'b0;
            start_reg     <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else if (en) begin
            tx_rem_reg    <= tx_rem_next;
            tx_active_reg <= tx_active_next;
            rx_ok_reg     <= rx_ok_next;
            tx_ok_reg     <= tx_ok_next;
            gap_cnt_reg   <= gap_cnt_next;
            rx_idle_reg   <= rx_idle_next;
            tx_idle_reg   <= tx_idle_next;
            dead_reg      <= dead_next;
            start_reg     <= start_next;
            stop_reg      <= stop_next;
        end
    end

    a_idle_sat: assert property (@(posedge clk) disable iff (!rst_n)
        $past(en) && $past(cmd) == CMD_TICK |-> rx_idle_reg < 16'hFFFF || reset_time == 16'hFFFF)
        else $error("receive idle counter passed its saturation point");

    a_stop_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        en && cmd == CMD_TICK && !start_reg && start_next |-> stop_next)
        else $error("frame start raised without frame stop");

    a_reset_clears_tx: assert property (@(posedge clk) disable iff (!rst_n)
        en && result.soft_reset |=> !tx_active_reg && tx_rem_reg == 16'd0 && !start_reg)
        else $error("soft reset left transmit or frame state behind");

endmodule

`default_nettype wire

@@ src/uart_rx_fifo_link_watchdog.sv @@
// Top level of the serial receive ring with transmit tracker and link watchdog.
`default_nettype none

// One item enters per clock while out_ready is high. An accepted item is held
// in an input register, is processed by the command logic and the ring once
// the output register can take it, and its result item is captured in the
// output register at the end of that cycle, so the sustained rate is one item
// per cycle while out_ready is high; the path from the input register through
// the watchdog compares and the ring memory's single write and registered read
// port sets the clock limit. A read returns the oldest byte; bytes never written
// to the ring are not readable. The user must write gap_time and reset_time
// through the configuration port only while no item is in flight; not enforced.
module uart_rx_fifo_link_watchdog (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [urfw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urfw_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          cmd,
    input  logic [7:0]                          data,
    input  logic [15:0]                         tx_length,
    input  logic                                rx_error,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [7:0]                          read_byte,
    output logic                                send_next,
    output logic [urfw_pkg::CNT_W-1:0]          queue_count,
    output logic                                tx_busy,
    output logic                                link_dead,
    output logic                                frame_start,
    output logic                                frame_stop,
    output logic                                soft_reset
);
    import urfw_pkg::*;

    logic [CFG_W-1:0] gap_time_reg;
    logic [CFG_W-1:0] reset_time_reg;
    logic             s1_valid_reg;
    logic [2:0]       cmd_reg;
    logic [7:0]       data_reg;
    logic [15:0]      len_reg;
    logic             err_reg;
    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res_next;
    ring_cmd_t        ring_cmd;
    ring_stat_t       ring_stat;
    logic             fire;
    logic             accept;

    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gap_time_reg   <= GAP_TIME_RST;
            reset_time_reg <= RESET_TIME_RST;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_GAP_TIME:   gap_time_reg   <= cfg_data;
                REG_RESET_TIME: reset_time_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_reg  <= cmd;
            data_reg <= data;
            len_reg  <= tx_length;
            err_reg  <= rx_error;
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    urfw_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_cmd  (ring_cmd),
        .ring_stat (ring_stat)
    );

    urfw_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (fire),
        .cmd        (cmd_reg),
        .data       (data_reg),
        .tx_length  (len_reg),
        .rx_error   (err_reg),
        .gap_time   (gap_time_reg),
        .reset_time (reset_time_reg),
        .ring_stat  (ring_stat),
        .ring_cmd   (ring_cmd),
        .result     (res_next)
    );

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign read_byte   = res_reg.read_byte;
    assign send_next   = res_reg.send_next;
    assign queue_count = res_reg.queue_count;
    assign tx_busy     = res_reg.tx_busy;
    assign link_dead   = res_reg.link_dead;
    assign frame_start = res_reg.frame_start;
    assign frame_stop  = res_reg.frame_stop;
    assign soft_reset  = res_reg.soft_reset;

endmodule

`default_nettype wire
